FILE: rtl/core/ihcs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and brand-matching functions for the image header sniffer.
// No dependencies; used by the top level and the testbench.
package ihcs_pkg;

    localparam int HEAD_BYTES  = 4096;
    localparam int POS_W       = $clog2(HEAD_BYTES + 1);
    localparam int STORE_DEPTH = 29;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int SUM_W       = ((POS_W > 16) ? POS_W : 16) + 2;

    typedef enum logic [3:0] {
        KIND_NONE        = 4'd0,
        KIND_VP8         = 4'd1,
        KIND_VP8L        = 4'd2,
        KIND_VP8X        = 4'd3,
        KIND_PNG         = 4'd4,
        KIND_AV1         = 4'd5,
        KIND_HEVC        = 4'd6,
        KIND_H264        = 4'd7,
        KIND_JPEG_BASE   = 4'd8,
        KIND_JPEG_PROGR  = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        WALK_RUNNING     = 2'd0,
        WALK_BASELINE    = 2'd1,
        WALK_PROGRESSIVE = 2'd2,
        WALK_STOPPED     = 2'd3
    } t_walk;

    localparam logic [31:0] CC_RIFF = 32'h5249_4646;
    localparam logic [31:0] CC_WEBP = 32'h5745_4250;
    localparam logic [31:0] CC_VP8  = 32'h5650_3820;
    localparam logic [31:0] CC_VP8L = 32'h5650_384C;
    localparam logic [31:0] CC_VP8X = 32'h5650_3858;
    localparam logic [31:0] CC_PNG0 = 32'h8950_4E47;
    localparam logic [31:0] CC_PNG1 = 32'h0D0A_1A0A;
    localparam logic [31:0] CC_FTYP = 32'h6674_7970;

    localparam logic [7:0] FLAG_ALPHA = 8'h10;
    localparam logic [7:0] FLAG_ANIM  = 8'h02;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF1   = 8'hC1;
    localparam logic [7:0] MK_SOF2   = 8'hC2;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_EOI    = 8'hD9;

    function automatic logic is_av1_brand(input logic [31:0] w);
        return (w == 32'h6176_3031) || (w == 32'h6176_6966) || (w == 32'h6176_6973);
    endfunction

    function automatic logic is_hevc_brand(input logic [31:0] w);
        return (w == 32'h6865_6963) || (w == 32'h6865_6978) || (w == 32'h6865_7663)
            || (w == 32'h6865_7678) || (w == 32'h6D73_6631) || (w == 32'h6865_6973);
    endfunction

    function automatic logic is_h264_brand(input logic [31:0] w);
        return (w == 32'h6176_6331) || (w == 32'h6176_6373);
    endfunction

endpackage

FILE: rtl/core/ihcs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on ihcs_pkg for nothing but sits after it in compile order.
interface ihcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihcs_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic       has_alpha;
    logic       has_animation;
    logic       colour_valid;
    logic [7:0] colour_type;
    logic [7:0] bit_depth;
    logic       interlaced;

    modport source (output valid, output kind, output has_alpha, output has_animation,
                    output colour_valid, output colour_type, output bit_depth,
                    output interlaced, input ready);
    modport sink   (input valid, input kind, input has_alpha, input has_animation,
                    input colour_valid, input colour_type, input bit_depth,
                    input interlaced, output ready);
endinterface

FILE: rtl/core/image_header_codec_sniffer.sv
`timescale 1ns / 1ps
// Image header sniffer top level: streams file-head bytes and reports the codec kind.
// Depends on ihcs_pkg and the channel interfaces in ihcs_if.sv.
//
//   Channel    Dir  Carries                         Word
//   i_byte     in   data_byte, last_byte            one byte of the file head
//   o_result   out  kind and the detail fields      one result per head
//
// One byte word is taken every cycle unless the input stalls; a word is registered, then
// folded into the running state, and the result is registered as its last byte is folded.
// Only a word marked last stalls the input, and only while the previous result is unread.
// Reset is synchronous, active low, and returns the block to an empty head.
module image_header_codec_sniffer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ihcs_in_if.sink          i_byte,
    ihcs_out_if.source       o_result
);

    localparam int PW = ihcs_pkg::POS_W;
    localparam int SW = ihcs_pkg::SUM_W;

    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    logic                      r_in_last;

    logic [PW-1:0]             r_pos,    n_pos,    upd_pos;
    logic [7:0]                r_store [ihcs_pkg::STORE_DEPTH];
    logic [7:0]                upd_store [ihcs_pkg::STORE_DEPTH];
    logic [31:0]               r_ws,     n_ws,     upd_ws;
    logic [2:0]                r_brands, n_brands, upd_brands;
    logic [PW-1:0]             r_seg,    n_seg,    upd_seg;
    logic [7:0]                r_seg_hi, n_seg_hi, upd_seg_hi;
    ihcs_pkg::t_walk           r_walk,   n_walk,   upd_walk;

    logic                      r_out_valid;
    ihcs_pkg::t_kind           r_kind,   n_kind;
    logic                      r_alpha,  n_alpha;
    logic                      r_anim,   n_anim;
    logic                      r_cvalid, n_cvalid;
    logic [7:0]                r_ctype,  n_ctype;
    logic [7:0]                r_depth,  n_depth;
    logic                      r_ilace,  n_ilace;

    logic                      advance;
    logic                      step;
    logic                      take;

    assign advance        = !r_in_valid || !r_in_last || !r_out_valid || o_result.ready;
    assign step           = r_in_valid && advance;
    assign take           = step && (r_pos < PW'(ihcs_pkg::HEAD_BYTES));
    assign i_byte.ready   = !r_in_valid || advance;

    always_comb begin
        logic [31:0]   box;
        logic [PW:0]   seg_p2;
        logic [PW:0]   seg_p3;
        logic [15:0]   seg_len;
        logic [SW-1:0] seg_sum;
        logic [7:0]    m0;
        logic [7:0]    m1;

        box      = {r_store[0], r_store[1], r_store[2], r_store[3]};
        seg_p2   = {1'b0, r_seg} + (PW+1)'(2);
        seg_p3   = {1'b0, r_seg} + (PW+1)'(3);
        seg_len  = {r_seg_hi, r_in_byte};
        seg_sum  = SW'(r_seg) + SW'(seg_len) + SW'(2);
        m0       = r_ws[23:16];
        m1       = r_ws[15:8];

        upd_pos    = r_pos;
        upd_store  = r_store;
        upd_ws     = r_ws;
        upd_brands = r_brands;
        upd_seg    = r_seg;
        upd_seg_hi = r_seg_hi;
        upd_walk   = r_walk;

        if (take) begin
            if (r_pos < PW'(ihcs_pkg::STORE_DEPTH)) begin
                upd_store[r_pos[ihcs_pkg::STORE_AW-1:0]] = r_in_byte;
            end
            upd_ws = {r_ws[23:0], r_in_byte};
            if ((r_pos >= PW'(11)) && (r_pos[1:0] == 2'b11)
                && ((box == 32'd0) || (32'(r_pos) < box))) begin
                if (ihcs_pkg::is_av1_brand(upd_ws))  upd_brands[0] = 1'b1;
                if (ihcs_pkg::is_hevc_brand(upd_ws)) upd_brands[1] = 1'b1;
                if (ihcs_pkg::is_h264_brand(upd_ws)) upd_brands[2] = 1'b1;
            end
            if (r_walk == ihcs_pkg::WALK_RUNNING) begin
                if ({1'b0, r_pos} == seg_p2) begin
                    upd_seg_hi = r_in_byte;
                end else if ({1'b0, r_pos} == seg_p3) begin
                    priority if (m0 != ihcs_pkg::MK_PREFIX) begin
                        upd_walk = ihcs_pkg::WALK_STOPPED;
                    end else if ((m1 == ihcs_pkg::MK_SOF0) || (m1 == ihcs_pkg::MK_SOF1)) begin
                        upd_walk = ihcs_pkg::WALK_BASELINE;
                    end else if (m1 == ihcs_pkg::MK_SOF2) begin
                        upd_walk = ihcs_pkg::WALK_PROGRESSIVE;
                    end else if ((m1 == ihcs_pkg::MK_SOS) || (m1 == ihcs_pkg::MK_EOI)) begin
                        upd_walk = ihcs_pkg::WALK_STOPPED;
                    end else if (seg_len < 16'd2) begin
                        upd_walk = ihcs_pkg::WALK_STOPPED;
                    end else if (seg_sum > SW'(ihcs_pkg::HEAD_BYTES)) begin
                        upd_seg = PW'(ihcs_pkg::HEAD_BYTES);
                    end else begin
                        upd_seg = seg_sum[PW-1:0];
                    end
                end
            end
            upd_pos = r_pos + PW'(1);
        end
    end

    always_comb begin
        logic [31:0] w0;
        logic [31:0] w4;
        logic [31:0] w8;
        logic [31:0] w12;
        logic [7:0]  ct;

        w0  = {upd_store[0],  upd_store[1],  upd_store[2],  upd_store[3]};
        w4  = {upd_store[4],  upd_store[5],  upd_store[6],  upd_store[7]};
        w8  = {upd_store[8],  upd_store[9],  upd_store[10], upd_store[11]};
        w12 = {upd_store[12], upd_store[13], upd_store[14], upd_store[15]};
        ct  = upd_store[25];

        n_kind   = ihcs_pkg::KIND_NONE;
        n_alpha  = 1'b0;
        n_anim   = 1'b0;
        n_cvalid = 1'b0;
        n_ctype  = 8'd0;
        n_depth  = 8'd0;
        n_ilace  = 1'b0;

        if (upd_pos >= PW'(16)) begin
            priority if ((w0 == ihcs_pkg::CC_RIFF) && (w8 == ihcs_pkg::CC_WEBP)) begin
                priority if (w12 == ihcs_pkg::CC_VP8) begin
                    n_kind = ihcs_pkg::KIND_VP8;
                end else if (w12 == ihcs_pkg::CC_VP8L) begin
                    n_kind = ihcs_pkg::KIND_VP8L;
                end else if ((w12 == ihcs_pkg::CC_VP8X) && (upd_pos >= PW'(21))) begin
                    n_kind  = ihcs_pkg::KIND_VP8X;
                    n_alpha = |(upd_store[20] & ihcs_pkg::FLAG_ALPHA);
                    n_anim  = |(upd_store[20] & ihcs_pkg::FLAG_ANIM);
                end else begin
                    n_kind = ihcs_pkg::KIND_NONE;
                end
            end else if ((upd_pos >= PW'(29)) && (w0 == ihcs_pkg::CC_PNG0)
                         && (w4 == ihcs_pkg::CC_PNG1)) begin
                n_kind   = ihcs_pkg::KIND_PNG;
                n_cvalid = (ct == 8'd0) || (ct == 8'd2) || (ct == 8'd3)
                        || (ct == 8'd4) || (ct == 8'd6);
                n_ctype  = ct;
                n_depth  = upd_store[24];
                n_ilace  = |upd_store[28];
            end else if (w4 == ihcs_pkg::CC_FTYP) begin
                priority if (upd_brands[0]) begin
                    n_kind = ihcs_pkg::KIND_AV1;
                end else if (upd_brands[1]) begin
                    n_kind = ihcs_pkg::KIND_HEVC;
                end else if (upd_brands[2]) begin
                    n_kind = ihcs_pkg::KIND_H264;
                end else begin
                    n_kind = ihcs_pkg::KIND_NONE;
                end
            end else if ((upd_store[0] == ihcs_pkg::MK_PREFIX)
                         && (upd_store[1] == ihcs_pkg::MK_SOI)) begin
                priority if (upd_walk == ihcs_pkg::WALK_BASELINE) begin
                    n_kind = ihcs_pkg::KIND_JPEG_BASE;
                end else if (upd_walk == ihcs_pkg::WALK_PROGRESSIVE) begin
                    n_kind = ihcs_pkg::KIND_JPEG_PROGR;
                end else begin
                    n_kind = ihcs_pkg::KIND_NONE;
                end
            end else begin
                n_kind = ihcs_pkg::KIND_NONE;
            end
        end
    end

    always_comb begin
        if (step && r_in_last) begin
            n_pos    = '0;
            n_ws     = '0;
            n_brands = '0;
            n_seg    = PW'(2);
            n_seg_hi = '0;
            n_walk   = ihcs_pkg::WALK_RUNNING;
        end else begin
            n_pos    = upd_pos;
            n_ws     = upd_ws;
            n_brands = upd_brands;
            n_seg    = upd_seg;
            n_seg_hi = upd_seg_hi;
            n_walk   = upd_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_ws        <= '0;
            r_brands    <= '0;
            r_seg       <= PW'(2);
            r_seg_hi    <= '0;
            r_walk      <= ihcs_pkg::WALK_RUNNING;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            r_out_valid <= (r_out_valid && !o_result.ready) || (step && r_in_last);
            r_pos       <= n_pos;
            r_ws        <= n_ws;
            r_brands    <= n_brands;
            r_seg       <= n_seg;
            r_seg_hi    <= n_seg_hi;
            r_walk      <= n_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
        if (take) begin
            r_store <= upd_store;
        end
        if (step && r_in_last) begin
            r_kind   <= n_kind;
            r_alpha  <= n_alpha;
            r_anim   <= n_anim;
            r_cvalid <= n_cvalid;
            r_ctype  <= n_ctype;
            r_depth  <= n_depth;
            r_ilace  <= n_ilace;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.kind          = r_kind;
    assign o_result.has_alpha     = r_alpha;
    assign o_result.has_animation = r_anim;
    assign o_result.colour_valid  = r_cvalid;
    assign o_result.colour_type   = r_ctype;
    assign o_result.bit_depth     = r_depth;
    assign o_result.interlaced    = r_ilace;

endmodule

FILE: bench/tb_image_header_codec_sniffer.sv
`timescale 1ns / 1ps
// Testbench for image_header_codec_sniffer: streams file heads one word at a time and
// checks every result against a byte-level predictor held in a scoreboard class.
// Depends on ihcs_pkg, the channel interfaces in ihcs_if.sv and the top level.
module tb_image_header_codec_sniffer;

    localparam int LIMIT_CYCLES     = 500000;
    localparam int RANDOM_BYTES     = 730;
    localparam int MIN_RANDOM_HEADS = 20;

    localparam logic [31:0] BRANDS [11] = '{
        "av01", "avif", "avis", "heic", "heix", "hevc", "hevx", "msf1", "heis", "avc1", "avcs"
    };
    localparam logic [7:0] FILLERS [6]     = '{8'hE0, 8'hE1, 8'hDB, 8'hC4, 8'hDD, 8'hFE};
    localparam logic [7:0] PNG_COLOURS [5] = '{8'd0, 8'd2, 8'd3, 8'd4, 8'd6};

    typedef struct packed {
        ihcs_pkg::t_kind kind;
        logic            alpha;
        logic            anim;
        logic            cvalid;
        logic [7:0]      ctype;
        logic [7:0]      depth;
        logic            ilace;
    } t_head_result;

    class kind_scoreboard;
        int unsigned     pos;
        logic [7:0]      head_bytes [ihcs_pkg::STORE_DEPTH];
        logic [31:0]     last4;
        logic [2:0]      groups;
        int unsigned     seg_at;
        logic [7:0]      seg_len_hi;
        ihcs_pkg::t_walk walk;
        t_head_result    expected_kinds [$];
        int              mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            pos        = 0;
            last4      = '0;
            groups     = '0;
            seg_at     = 2;
            seg_len_hi = '0;
            walk       = ihcs_pkg::WALK_RUNNING;
            foreach (head_bytes[k]) head_bytes[k] = '0;
        endfunction

        function logic [31:0] head_word(int off);
            return {head_bytes[off], head_bytes[off + 1], head_bytes[off + 2],
                    head_bytes[off + 3]};
        endfunction

        function logic [2:0] brand_bits(logic [31:0] w);
            logic [2:0] g;
            g = '0;
            for (int k = 0; k < 11; k++) begin
                if (w == BRANDS[k]) begin
                    g[(k < 3) ? 0 : (k < 9) ? 1 : 2] = 1'b1;
                end
            end
            return g;
        endfunction

        function void fold_byte(logic [7:0] b);
            int unsigned p;
            logic [31:0] box;
            logic [15:0] seg_len;
            p = pos;
            if (p < ihcs_pkg::STORE_DEPTH) head_bytes[p] = b;
            last4 = {last4[23:0], b};
            if (p >= 11 && (p % 4) == 3) begin
                box = head_word(0);
                if (box == 0 || p < box) groups = groups | brand_bits(last4);
            end
            if (walk == ihcs_pkg::WALK_RUNNING) begin
                if (p == seg_at + 2) begin
                    seg_len_hi = b;
                end else if (p == seg_at + 3) begin
                    seg_len = {seg_len_hi, b};
                    if (last4[31:24] != ihcs_pkg::MK_PREFIX) begin
                        walk = ihcs_pkg::WALK_STOPPED;
                    end else if (last4[23:16] == ihcs_pkg::MK_SOF0
                                 || last4[23:16] == ihcs_pkg::MK_SOF1) begin
                        walk = ihcs_pkg::WALK_BASELINE;
                    end else if (last4[23:16] == ihcs_pkg::MK_SOF2) begin
                        walk = ihcs_pkg::WALK_PROGRESSIVE;
                    end else if (last4[23:16] == ihcs_pkg::MK_SOS
                                 || last4[23:16] == ihcs_pkg::MK_EOI) begin
                        walk = ihcs_pkg::WALK_STOPPED;
                    end else if (seg_len < 2) begin
                        walk = ihcs_pkg::WALK_STOPPED;
                    end else begin
                        seg_at = seg_at + 2 + seg_len;
                    end
                end
            end
            pos = p + 1;
        endfunction

        function t_head_result classify_head();
            t_head_result r;
            logic [31:0]  chunk;
            r = '0;
            if (pos < 16) return r;
            if (head_word(0) == ihcs_pkg::CC_RIFF && head_word(8) == ihcs_pkg::CC_WEBP) begin
                chunk = head_word(12);
                if (chunk == ihcs_pkg::CC_VP8) begin
                    r.kind = ihcs_pkg::KIND_VP8;
                end else if (chunk == ihcs_pkg::CC_VP8L) begin
                    r.kind = ihcs_pkg::KIND_VP8L;
                end else if (chunk == ihcs_pkg::CC_VP8X && pos >= 21) begin
                    r.kind  = ihcs_pkg::KIND_VP8X;
                    r.alpha = |(head_bytes[20] & ihcs_pkg::FLAG_ALPHA);
                    r.anim  = |(head_bytes[20] & ihcs_pkg::FLAG_ANIM);
                end
                return r;
            end
            if (pos >= 29 && head_word(0) == ihcs_pkg::CC_PNG0
                    && head_word(4) == ihcs_pkg::CC_PNG1) begin
                r.kind  = ihcs_pkg::KIND_PNG;
                r.ctype = head_bytes[25];
                r.depth = head_bytes[24];
                r.ilace = |head_bytes[28];
                foreach (PNG_COLOURS[k]) begin
                    if (r.ctype == PNG_COLOURS[k]) r.cvalid = 1'b1;
                end
                return r;
            end
            if (head_word(4) == ihcs_pkg::CC_FTYP) begin
                if (groups[0]) r.kind = ihcs_pkg::KIND_AV1;
                else if (groups[1]) r.kind = ihcs_pkg::KIND_HEVC;
                else if (groups[2]) r.kind = ihcs_pkg::KIND_H264;
                return r;
            end
            if (head_bytes[0] == ihcs_pkg::MK_PREFIX && head_bytes[1] == ihcs_pkg::MK_SOI) begin
                if (walk == ihcs_pkg::WALK_BASELINE) r.kind = ihcs_pkg::KIND_JPEG_BASE;
                else if (walk == ihcs_pkg::WALK_PROGRESSIVE) r.kind = ihcs_pkg::KIND_JPEG_PROGR;
            end
            return r;
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            if (pos < ihcs_pkg::HEAD_BYTES) fold_byte(b);
            if (fin) begin
                expected_kinds.push_back(classify_head());
                clear();
            end
        endfunction

        function void check_result(t_head_result got);
            t_head_result want;
            if (expected_kinds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with none expected, kind=%0d", $time, got.kind);
                end
                return;
            end
            want = expected_kinds.pop_front();
            if (got.kind !== want.kind || got.alpha !== want.alpha || got.anim !== want.anim
                    || got.cvalid !== want.cvalid || got.ctype !== want.ctype
                    || got.depth !== want.depth || got.ilace !== want.ilace) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: expected kind=%0d alpha=%b anim=%b cvalid=%b %s",
                             $time, want.kind, want.alpha, want.anim, want.cvalid,
                             $sformatf("ctype=%h depth=%h ilace=%b",
                                       want.ctype, want.depth, want.ilace));
                    $display("%0t: actual   kind=%0d alpha=%b anim=%b cvalid=%b %s",
                             $time, got.kind, got.alpha, got.anim, got.cvalid,
                             $sformatf("ctype=%h depth=%h ilace=%b",
                                       got.ctype, got.depth, got.ilace));
                end
            end
        endfunction
    endclass

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    int             cycles  = 0;
    int             send_idle_pct;
    int             take_idle_pct;
    logic [7:0]     head_q [$];
    kind_scoreboard board;

    ihcs_in_if  byte_ch ();
    ihcs_out_if result_ch ();

    image_header_codec_sniffer u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_image_header_codec_sniffer: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            board.check_result(t_head_result'({result_ch.kind, result_ch.has_alpha,
                result_ch.has_animation, result_ch.colour_valid, result_ch.colour_type,
                result_ch.bit_depth, result_ch.interlaced}));
        end
        result_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end

    function automatic void push_word(logic [31:0] w);
        head_q.push_back(w[31:24]);
        head_q.push_back(w[23:16]);
        head_q.push_back(w[15:8]);
        head_q.push_back(w[7:0]);
    endfunction

    function automatic void fit_to(int n);
        while (head_q.size() > n) void'(head_q.pop_back());
        while (head_q.size() < n) head_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [31:0] pick_brand();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return BRANDS[$urandom_range(0, 10)];
    endfunction

    function automatic void build_webp(logic [31:0] chunk, logic [7:0] flags, int len);
        head_q.delete();
        push_word(ihcs_pkg::CC_RIFF);
        push_word($urandom);
        push_word(ihcs_pkg::CC_WEBP);
        push_word(chunk);
        push_word($urandom);
        head_q.push_back(flags);
        fit_to(len);
    endfunction

    function automatic void build_png(logic [7:0] ctype, logic [7:0] depth, logic [7:0] ilace,
                                      int len);
        head_q.delete();
        push_word(ihcs_pkg::CC_PNG0);
        push_word(ihcs_pkg::CC_PNG1);
        push_word(32'd13);
        push_word("IHDR");
        push_word($urandom);
        push_word($urandom);
        head_q.push_back(depth);
        head_q.push_back(ctype);
        head_q.push_back(8'd0);
        head_q.push_back(8'd0);
        head_q.push_back(ilace);
        fit_to(len);
    endfunction

    function automatic void build_ftyp(logic [31:0] box, logic [31:0] b0, logic [31:0] b1,
                                       int extra, int len);
        head_q.delete();
        push_word(box);
        push_word(ihcs_pkg::CC_FTYP);
        push_word(b0);
        push_word(b1);
        repeat (extra) push_word(pick_brand());
        fit_to(len);
    endfunction

    function automatic void build_jpeg(logic [7:0] prefix, logic [7:0] marker,
                                       logic [15:0] seg_len, int nfill, int fill_len, int len);
        logic [15:0] flen;
        flen = 16'(fill_len);
        head_q.delete();
        head_q.push_back(ihcs_pkg::MK_PREFIX);
        head_q.push_back(ihcs_pkg::MK_SOI);
        repeat (nfill) begin
            head_q.push_back(ihcs_pkg::MK_PREFIX);
            head_q.push_back(FILLERS[$urandom_range(0, 5)]);
            head_q.push_back(flen[15:8]);
            head_q.push_back(flen[7:0]);
            for (int i = 2; i < fill_len; i++) head_q.push_back(8'($urandom_range(0, 255)));
        end
        head_q.push_back(prefix);
        head_q.push_back(marker);
        head_q.push_back(seg_len[15:8]);
        head_q.push_back(seg_len[7:0]);
        fit_to(len);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= fin;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        board.note_byte(b, fin);
    endtask

    task automatic send_head();
        for (int i = 0; i < head_q.size(); i++) begin
            send_byte(head_q[i], i == head_q.size() - 1);
        end
    endtask

    initial begin
        int          sent;
        int          heads;
        logic [31:0] w;
        logic [7:0]  ct;
        logic [7:0]  mk;

        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        send_idle_pct     = 13;
        take_idle_pct     = 68;
        sent              = 0;
        heads             = 0;
        board             = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        head_q = '{8'hFF};
        send_head();
        head_q = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                   8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        send_head();
        build_webp(ihcs_pkg::CC_VP8, 8'h00, 16);
        send_head();
        build_webp(ihcs_pkg::CC_VP8L, 8'hFF, 30);
        send_head();
        build_webp(ihcs_pkg::CC_VP8X, ihcs_pkg::FLAG_ALPHA | ihcs_pkg::FLAG_ANIM, 21);
        send_head();
        build_webp(ihcs_pkg::CC_VP8X, 8'hED, 30);
        send_head();
        build_webp(ihcs_pkg::CC_VP8X, 8'hFF, 20);
        send_head();
        build_webp("ALPH", 8'h12, 30);
        send_head();
        build_png(8'd6, 8'd8, 8'd1, 29);
        send_head();
        build_png(8'd5, 8'd16, 8'd0, 40);
        send_head();
        build_png(8'd2, 8'd8, 8'hFF, 28);
        send_head();
        build_ftyp(32'd0, "isom", "av01", 0, 16);
        send_head();
        build_ftyp(32'd24, "heic", "mif1", 0, 16);
        send_head();
        build_ftyp(32'd12, "mif1", "avc1", 0, 16);
        send_head();
        build_ftyp(32'd16, "avc1", "heic", 0, 16);
        send_head();
        build_ftyp(32'hFFFF_FFFF, "avis", "hevc", 0, 16);
        send_head();
        build_ftyp(32'd0, "mp41", "avcs", 0, 16);
        send_head();
        build_ftyp(32'd0, "mp41", "isom", 0, 16);
        send_head();
        build_jpeg(ihcs_pkg::MK_PREFIX, ihcs_pkg::MK_SOF0, 16'd17, 1, 6, 24);
        send_head();
        build_jpeg(ihcs_pkg::MK_PREFIX, ihcs_pkg::MK_SOF1, 16'd11, 0, 2, 20);
        send_head();
        build_jpeg(ihcs_pkg::MK_PREFIX, ihcs_pkg::MK_SOF2, 16'd17, 2, 5, 32);
        send_head();
        build_jpeg(ihcs_pkg::MK_PREFIX, ihcs_pkg::MK_SOS, 16'd12, 1, 4, 32);
        send_head();
        build_jpeg(ihcs_pkg::MK_PREFIX, ihcs_pkg::MK_EOI, 16'd2, 0, 2, 20);
        send_head();
        build_jpeg(ihcs_pkg::MK_PREFIX, 8'hE0, 16'd1, 0, 2, 24);
        send_head();
        build_jpeg(8'h00, ihcs_pkg::MK_SOF0, 16'd17, 0, 2, 24);
        send_head();
        build_jpeg(ihcs_pkg::MK_PREFIX, ihcs_pkg::MK_SOF0, 16'd17, 2, 6, 21);
        send_head();

        while (sent < RANDOM_BYTES || heads < MIN_RANDOM_HEADS) begin
            if (sent >= 2 * RANDOM_BYTES / 3) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end else if (sent >= RANDOM_BYTES / 3) begin
                send_idle_pct = 68;
                take_idle_pct = 13;
            end
            case ($urandom_range(0, 9))
                0: begin
                    head_q.delete();
                    fit_to($urandom_range(1, 40));
                end
                1: begin
                    head_q.delete();
                    fit_to($urandom_range(1, 15));
                end
                2: begin
                    case ($urandom_range(0, 3))
                        0: w = ihcs_pkg::CC_VP8;
                        1: w = ihcs_pkg::CC_VP8L;
                        2: w = ihcs_pkg::CC_VP8X;
                        default: w = $urandom;
                    endcase
                    build_webp(w, 8'($urandom_range(0, 255)), $urandom_range(14, 40));
                end
                3: begin
                    ct = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : PNG_COLOURS[$urandom_range(0, 4)];
                    build_png(ct, 8'($urandom_range(0, 255)),
                              ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255))
                                                          : 8'($urandom_range(0, 1)),
                              $urandom_range(26, 48));
                end
                4, 5: begin
                    case ($urandom_range(0, 3))
                        0: w = 32'd0;
                        1: w = 8 + 4 * $urandom_range(0, 8);
                        2: w = $urandom_range(9, 40);
                        default: w = $urandom;
                    endcase
                    build_ftyp(w, pick_brand(), pick_brand(), $urandom_range(0, 6),
                               $urandom_range(14, 44));
                end
                default: begin
                    case ($urandom_range(0, 7))
                        0: mk = ihcs_pkg::MK_SOF0;
                        1: mk = ihcs_pkg::MK_SOF1;
                        2: mk = ihcs_pkg::MK_SOF2;
                        3: mk = ihcs_pkg::MK_SOS;
                        4: mk = ihcs_pkg::MK_EOI;
                        5: mk = 8'hE0;
                        6: mk = 8'($urandom_range(0, 255));
                        default: mk = ihcs_pkg::MK_SOF2;
                    endcase
                    build_jpeg(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                           : ihcs_pkg::MK_PREFIX,
                               mk,
                               ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1))
                                                           : 16'($urandom_range(2, 20)),
                               $urandom_range(0, 3),
                               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                           : $urandom_range(2, 12),
                               $urandom_range(12, 52));
                end
            endcase
            if ($urandom_range(0, 7) == 0) begin
                head_q[$urandom_range(0, head_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            sent  += head_q.size();
            heads += 1;
            send_head();
        end
        byte_ch.valid <= 1'b0;

        while (board.expected_kinds.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("tb_image_header_codec_sniffer: PASS");
        end else begin
            $display("tb_image_header_codec_sniffer: FAIL");
        end
        $finish;
    end

endmodule
